// ----- rtl/gbfp_pkg.sv -----
package gbfp_pkg;

   // frame constants
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // register port widths
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // register reset values
   localparam logic [15:0] GAP_LIMIT_RST       = 16'd2500;
   localparam logic [7:0]  LOWEST_CLASS_RST    = 8'h01;
   localparam logic [7:0]  HIGHEST_CLASS_RST   = 8'h28;
   localparam logic [15:0] LONGEST_PAYLOAD_RST = 16'hFFFF;

   // saturation value of the silence counter
   localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GAP_LIMIT       = 8'd0,
      REG_LOWEST_CLASS    = 8'd1,
      REG_HIGHEST_CLASS   = 8'd2,
      REG_LONGEST_PAYLOAD = 8'd3
   } csr_index_type;

   // parser phases
   typedef enum logic [3:0] {
      PH_HUNT1    = 4'd0,
      PH_HUNT2    = 4'd1,
      PH_CLASS    = 4'd2,
      PH_ID       = 4'd3,
      PH_LEN_LO   = 4'd4,
      PH_LEN_HI   = 4'd5,
      PH_PAYLOAD  = 4'd6,
      PH_CK_A     = 4'd7,
      PH_CK_B_OK  = 4'd8,
      PH_CK_B_BAD = 4'd9
   } phase_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_HUNT     = 3'd0,
      ST_HEADER   = 3'd1,
      ST_PAYLOAD  = 3'd2,
      ST_OK       = 3'd3,
      ST_CKBAD    = 3'd4,
      ST_CLASSBAD = 3'd5,
      ST_GAP      = 3'd6,
      ST_LONG     = 3'd7
   } status_type;

   // configuration seen by the parser
   typedef struct packed {
      logic [15:0] gap_limit;
      logic [7:0]  lowest_class;
      logic [7:0]  highest_class;
      logic [15:0] longest_payload;
   } cfg_type;

endpackage

// ----- rtl/gbfp_if.sv -----
// input channel: one byte or one tick per transaction
interface gbfp_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// result channel: one result per transaction
interface gbfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  payload_byte;
   logic [15:0] payload_index;
   logic [7:0]  msg_class;
   logic [7:0]  msg_id;
   logic [15:0] msg_length;

   modport source (output valid, output status, output payload_byte, output payload_index,
                   output msg_class, output msg_id, output msg_length, input ready);
   modport sink   (input valid, input status, input payload_byte, input payload_index,
                   input msg_class, input msg_id, input msg_length, output ready);
endinterface

// configuration write channel
interface gbfp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gbfp_pkg::CSR_INDEX_W-1:0] index;
   logic [gbfp_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/gbfp_regs.sv -----
module gbfp_regs (
   input  logic              clock,
   input  logic              reset,
   gbfp_csr_if.sink          csr_chan,
   output gbfp_pkg::cfg_type cfg
);

   gbfp_pkg::cfg_type cfg_ff;
   gbfp_pkg::cfg_type cfg_in;
   logic              wr_en;

   // writes are always taken
   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;

   // register decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (gbfp_pkg::csr_index_type'(csr_chan.index))
            gbfp_pkg::REG_GAP_LIMIT:       cfg_in.gap_limit       = csr_chan.data;
            gbfp_pkg::REG_LOWEST_CLASS:    cfg_in.lowest_class    = csr_chan.data[7:0];
            gbfp_pkg::REG_HIGHEST_CLASS:   cfg_in.highest_class   = csr_chan.data[7:0];
            gbfp_pkg::REG_LONGEST_PAYLOAD: cfg_in.longest_payload = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_limit       <= gbfp_pkg::GAP_LIMIT_RST;
         cfg_ff.lowest_class    <= gbfp_pkg::LOWEST_CLASS_RST;
         cfg_ff.highest_class   <= gbfp_pkg::HIGHEST_CLASS_RST;
         cfg_ff.longest_payload <= gbfp_pkg::LONGEST_PAYLOAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/gnss_binary_frame_parser.sv -----
// result: registered, on the rsp channel in the cycle after its input transaction
// throughput: one transaction per cycle; the single result register sets the pace and
//   a new input is taken whenever that register is empty or being drained in the same cycle
// reset: synchronous, active high; parser returns to sync hunting with cleared sums,
//   counters and frame fields, and the configuration registers take their defaults
module gnss_binary_frame_parser (
   input  logic       clock,
   input  logic       reset,
   gbfp_req_if.sink   req_chan,
   gbfp_rsp_if.source rsp_chan,
   gbfp_csr_if.sink   csr_chan
);

   gbfp_pkg::cfg_type cfg;

   // parser state
   gbfp_pkg::phase_type phase_ff, phase_in;
   logic [15:0] byte_pos_ff, byte_pos_in;
   logic [15:0] pay_len_ff, pay_len_in;
   logic [7:0]  frame_class_ff, frame_class_in;
   logic [7:0]  frame_id_ff, frame_id_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [15:0] silence_ff, silence_in;
   logic        byte_seen_ff, byte_seen_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [7:0]  rsp_pbyte_ff;
   logic [15:0] rsp_pindex_ff;
   logic [7:0]  rsp_class_ff;
   logic [7:0]  rsp_id_ff;
   logic [15:0] rsp_length_ff;

   gbfp_pkg::status_type res_status;
   logic [7:0]  res_pbyte;
   logic [15:0] res_pindex;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  sum_a_add;
   logic [7:0]  sum_b_add;
   logic [15:0] silence_inc;
   logic [15:0] len_full;
   logic [15:0] pos_next;

   gbfp_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // take a new transaction when the result slot is free or drains now
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;

   // fletcher sums, length assembly, counters
   assign sum_a_add   = sum_a_ff + b;
   assign sum_b_add   = sum_b_ff + sum_a_add;
   assign silence_inc = (silence_ff == gbfp_pkg::SILENCE_MAX) ? silence_ff : silence_ff + 16'd1;
   assign len_full    = {b, pay_len_ff[7:0]};
   assign pos_next    = byte_pos_ff + 16'd1;

   // next state and result for one transaction
   always_comb begin
      phase_in       = phase_ff;
      byte_pos_in    = byte_pos_ff;
      pay_len_in     = pay_len_ff;
      frame_class_in = frame_class_ff;
      frame_id_in    = frame_id_ff;
      sum_a_in       = sum_a_ff;
      sum_b_in       = sum_b_ff;
      silence_in     = silence_ff;
      byte_seen_in   = byte_seen_ff;
      res_status     = gbfp_pkg::ST_HUNT;
      res_pbyte      = 8'd0;
      res_pindex     = 16'd0;

      if (accept) begin
         if (req_chan.mode) begin
            // time tick: count silence, drop a partial frame on timeout
            silence_in = silence_inc;
            if (byte_seen_ff && phase_ff != gbfp_pkg::PH_HUNT1 &&
                silence_inc > cfg.gap_limit) begin
               phase_in   = gbfp_pkg::PH_HUNT1;
               res_status = gbfp_pkg::ST_GAP;
            end
         end else begin
            silence_in   = 16'd0;
            byte_seen_in = 1'b1;
            case (phase_ff)
               gbfp_pkg::PH_HUNT1: begin
                  if (b == gbfp_pkg::SYNC_FIRST) phase_in = gbfp_pkg::PH_HUNT2;
               end
               gbfp_pkg::PH_HUNT2: begin
                  if (b == gbfp_pkg::SYNC_SECOND) begin
                     phase_in       = gbfp_pkg::PH_CLASS;
                     frame_class_in = 8'd0;
                     frame_id_in    = 8'd0;
                     pay_len_in     = 16'd0;
                     sum_a_in       = 8'd0;
                     sum_b_in       = 8'd0;
                     res_status     = gbfp_pkg::ST_HEADER;
                  end else if (b != gbfp_pkg::SYNC_FIRST) begin
                     phase_in = gbfp_pkg::PH_HUNT1;
                  end
               end
               gbfp_pkg::PH_CLASS: begin
                  sum_a_in       = sum_a_add;
                  sum_b_in       = sum_b_add;
                  frame_class_in = b;
                  if (b < cfg.lowest_class || b > cfg.highest_class) begin
                     phase_in   = gbfp_pkg::PH_HUNT1;
                     res_status = gbfp_pkg::ST_CLASSBAD;
                  end else begin
                     phase_in   = gbfp_pkg::PH_ID;
                     res_status = gbfp_pkg::ST_HEADER;
                  end
               end
               gbfp_pkg::PH_ID: begin
                  sum_a_in    = sum_a_add;
                  sum_b_in    = sum_b_add;
                  frame_id_in = b;
                  phase_in    = gbfp_pkg::PH_LEN_LO;
                  res_status  = gbfp_pkg::ST_HEADER;
               end
               gbfp_pkg::PH_LEN_LO: begin
                  sum_a_in   = sum_a_add;
                  sum_b_in   = sum_b_add;
                  pay_len_in = {8'd0, b};
                  phase_in   = gbfp_pkg::PH_LEN_HI;
                  res_status = gbfp_pkg::ST_HEADER;
               end
               gbfp_pkg::PH_LEN_HI: begin
                  sum_a_in    = sum_a_add;
                  sum_b_in    = sum_b_add;
                  pay_len_in  = len_full;
                  byte_pos_in = 16'd0;
                  if (len_full > cfg.longest_payload) begin
                     phase_in   = gbfp_pkg::PH_HUNT1;
                     res_status = gbfp_pkg::ST_LONG;
                  end else begin
                     phase_in   = (len_full == 16'd0) ? gbfp_pkg::PH_CK_A
                                                      : gbfp_pkg::PH_PAYLOAD;
                     res_status = gbfp_pkg::ST_HEADER;
                  end
               end
               gbfp_pkg::PH_PAYLOAD: begin
                  sum_a_in    = sum_a_add;
                  sum_b_in    = sum_b_add;
                  res_pbyte   = b;
                  res_pindex  = byte_pos_ff;
                  res_status  = gbfp_pkg::ST_PAYLOAD;
                  byte_pos_in = pos_next;
                  if (pos_next >= pay_len_ff) phase_in = gbfp_pkg::PH_CK_A;
               end
               gbfp_pkg::PH_CK_A: begin
                  phase_in   = (b == sum_a_ff) ? gbfp_pkg::PH_CK_B_OK : gbfp_pkg::PH_CK_B_BAD;
                  res_status = gbfp_pkg::ST_HEADER;
               end
               gbfp_pkg::PH_CK_B_OK: begin
                  res_status = (b == sum_b_ff) ? gbfp_pkg::ST_OK : gbfp_pkg::ST_CKBAD;
                  phase_in   = gbfp_pkg::PH_HUNT1;
               end
               gbfp_pkg::PH_CK_B_BAD: begin
                  res_status = gbfp_pkg::ST_CKBAD;
                  phase_in   = gbfp_pkg::PH_HUNT1;
               end
               default: begin
                  phase_in = gbfp_pkg::PH_HUNT1;
               end
            endcase
         end
      end
   end

   // result slot occupancy
   always_comb begin
      if (accept)              rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   // control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= gbfp_pkg::PH_HUNT1;
         byte_pos_ff    <= 16'd0;
         pay_len_ff     <= 16'd0;
         frame_class_ff <= 8'd0;
         frame_id_ff    <= 8'd0;
         sum_a_ff       <= 8'd0;
         sum_b_ff       <= 8'd0;
         silence_ff     <= 16'd0;
         byte_seen_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         byte_pos_ff    <= byte_pos_in;
         pay_len_ff     <= pay_len_in;
         frame_class_ff <= frame_class_in;
         frame_id_ff    <= frame_id_in;
         sum_a_ff       <= sum_a_in;
         sum_b_ff       <= sum_b_in;
         silence_ff     <= silence_in;
         byte_seen_ff   <= byte_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded per transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= res_status;
         rsp_pbyte_ff  <= res_pbyte;
         rsp_pindex_ff <= res_pindex;
         rsp_class_ff  <= frame_class_in;
         rsp_id_ff     <= frame_id_in;
         rsp_length_ff <= pay_len_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.payload_byte  = rsp_pbyte_ff;
   assign rsp_chan.payload_index = rsp_pindex_ff;
   assign rsp_chan.msg_class     = rsp_class_ff;
   assign rsp_chan.msg_id        = rsp_id_ff;
   assign rsp_chan.msg_length    = rsp_length_ff;

endmodule

// ----- rtl/gbfp_checker.sv -----
module gbfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_payload_byte,
   input logic [15:0] rsp_payload_index
);

   // every accepted transaction yields a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no result after accepted transaction");

   // a tick only reports hunting or a gap drop
   a_tick_status: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode) |=>
      (rsp_status == gbfp_pkg::ST_HUNT || rsp_status == gbfp_pkg::ST_GAP))
      else $error("tick gave a frame status");

   // payload fields are zero unless a payload byte is reported
   a_payload_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != gbfp_pkg::ST_PAYLOAD) |->
      (rsp_payload_byte == 8'd0 && rsp_payload_index == 16'd0))
      else $error("payload fields set outside payload");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind gnss_binary_frame_parser gbfp_checker u_gbfp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_mode          (req_chan.mode),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_payload_byte  (rsp_chan.payload_byte),
   .rsp_payload_index (rsp_chan.payload_index)
);

// ----- dv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one expected or observed result transaction
   typedef struct {
      gbfp_pkg::status_type status;
      logic [7:0]           payload_byte;
      logic [15:0]          payload_index;
      logic [7:0]           msg_class;
      logic [7:0]           msg_id;
      logic [15:0]          msg_length;
   } report_type;

   // frame tracker: follows the parser state and checks every report
   class frame_tracker;
      gbfp_pkg::cfg_type   cfg = '{gbfp_pkg::GAP_LIMIT_RST, gbfp_pkg::LOWEST_CLASS_RST,
                                   gbfp_pkg::HIGHEST_CLASS_RST,
                                   gbfp_pkg::LONGEST_PAYLOAD_RST};
      gbfp_pkg::phase_type phase = gbfp_pkg::PH_HUNT1;
      logic [15:0] position = '0;
      logic [15:0] length = '0;
      logic [15:0] silence = '0;
      logic [7:0]  frame_class = '0;
      logic [7:0]  frame_id = '0;
      logic [7:0]  sum_a = '0;
      logic [7:0]  sum_b = '0;
      bit          byte_seen = 1'b0;
      report_type  report_queue[$];
      int          failures = 0;

      function void set_register(gbfp_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            gbfp_pkg::REG_GAP_LIMIT:       cfg.gap_limit = value;
            gbfp_pkg::REG_LOWEST_CLASS:    cfg.lowest_class = value[7:0];
            gbfp_pkg::REG_HIGHEST_CLASS:   cfg.highest_class = value[7:0];
            gbfp_pkg::REG_LONGEST_PAYLOAD: cfg.longest_payload = value;
            default: ;
         endcase
      endfunction

      // running fletcher sums over class through payload
      function void add_to_sums(logic [7:0] b);
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
      endfunction

      // accepted input: advance the parser and queue the report it causes
      function void take_item(logic is_tick, logic [7:0] b);
         report_type r;
         r.status = gbfp_pkg::ST_HUNT;
         r.payload_byte = '0;
         r.payload_index = '0;
         if (is_tick) begin
            if (silence != gbfp_pkg::SILENCE_MAX) silence++;
            if (byte_seen && phase != gbfp_pkg::PH_HUNT1 && silence > cfg.gap_limit) begin
               phase = gbfp_pkg::PH_HUNT1;
               r.status = gbfp_pkg::ST_GAP;
            end
         end else begin
            silence = '0;
            byte_seen = 1'b1;
            case (phase)
               gbfp_pkg::PH_HUNT1: begin
                  if (b == gbfp_pkg::SYNC_FIRST) phase = gbfp_pkg::PH_HUNT2;
               end
               gbfp_pkg::PH_HUNT2: begin
                  if (b == gbfp_pkg::SYNC_SECOND) begin
                     phase = gbfp_pkg::PH_CLASS;
                     frame_class = '0;
                     frame_id = '0;
                     length = '0;
                     sum_a = '0;
                     sum_b = '0;
                     r.status = gbfp_pkg::ST_HEADER;
                  end else if (b != gbfp_pkg::SYNC_FIRST) begin
                     phase = gbfp_pkg::PH_HUNT1;
                  end
               end
               gbfp_pkg::PH_CLASS: begin
                  add_to_sums(b);
                  frame_class = b;
                  if (b < cfg.lowest_class || b > cfg.highest_class) begin
                     phase = gbfp_pkg::PH_HUNT1;
                     r.status = gbfp_pkg::ST_CLASSBAD;
                  end else begin
                     phase = gbfp_pkg::PH_ID;
                     r.status = gbfp_pkg::ST_HEADER;
                  end
               end
               gbfp_pkg::PH_ID: begin
                  add_to_sums(b);
                  frame_id = b;
                  phase = gbfp_pkg::PH_LEN_LO;
                  r.status = gbfp_pkg::ST_HEADER;
               end
               gbfp_pkg::PH_LEN_LO: begin
                  add_to_sums(b);
                  length = {8'h00, b};
                  phase = gbfp_pkg::PH_LEN_HI;
                  r.status = gbfp_pkg::ST_HEADER;
               end
               gbfp_pkg::PH_LEN_HI: begin
                  add_to_sums(b);
                  length = {b, length[7:0]};
                  position = '0;
                  if (length > cfg.longest_payload) begin
                     phase = gbfp_pkg::PH_HUNT1;
                     r.status = gbfp_pkg::ST_LONG;
                  end else begin
                     phase = (length == 16'd0) ? gbfp_pkg::PH_CK_A : gbfp_pkg::PH_PAYLOAD;
                     r.status = gbfp_pkg::ST_HEADER;
                  end
               end
               gbfp_pkg::PH_PAYLOAD: begin
                  add_to_sums(b);
                  r.payload_byte = b;
                  r.payload_index = position;
                  r.status = gbfp_pkg::ST_PAYLOAD;
                  position++;
                  if (position >= length) phase = gbfp_pkg::PH_CK_A;
               end
               gbfp_pkg::PH_CK_A: begin
                  phase = (b == sum_a) ? gbfp_pkg::PH_CK_B_OK : gbfp_pkg::PH_CK_B_BAD;
                  r.status = gbfp_pkg::ST_HEADER;
               end
               gbfp_pkg::PH_CK_B_OK: begin
                  r.status = (b == sum_b) ? gbfp_pkg::ST_OK : gbfp_pkg::ST_CKBAD;
                  phase = gbfp_pkg::PH_HUNT1;
               end
               gbfp_pkg::PH_CK_B_BAD: begin
                  r.status = gbfp_pkg::ST_CKBAD;
                  phase = gbfp_pkg::PH_HUNT1;
               end
               default: phase = gbfp_pkg::PH_HUNT1;
            endcase
         end
         r.msg_class = frame_class;
         r.msg_id = frame_id;
         r.msg_length = length;
         report_queue.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $error("%s expected %0h got %0h", name, want, seen);
            failures++;
         end
      endfunction

      // accepted result: compare with the oldest expected report
      function void check_report(report_type seen);
         report_type want;
         if (report_queue.size() == 0) begin
            $error("result transaction with no expected report");
            failures++;
            return;
         end
         want = report_queue.pop_front();
         compare_field("status", 16'(want.status), 16'(seen.status));
         compare_field("payload_byte", 16'(want.payload_byte), 16'(seen.payload_byte));
         compare_field("payload_index", want.payload_index, seen.payload_index);
         compare_field("msg_class", 16'(want.msg_class), 16'(seen.msg_class));
         compare_field("msg_id", 16'(want.msg_id), 16'(seen.msg_id));
         compare_field("msg_length", want.msg_length, seen.msg_length);
      endfunction

      function int pending();
         return report_queue.size();
      endfunction
   endclass

   localparam longint CYCLE_LIMIT = 2000000;
   localparam int     PHASES = 6;
   localparam int     PHASE_ITEMS = 110;
   localparam int     HOLD_CYCLES = 300;

   // register settings per phase, reset values first
   localparam gbfp_pkg::cfg_type PHASE_CFG [PHASES] = '{
      '{gbfp_pkg::GAP_LIMIT_RST, gbfp_pkg::LOWEST_CLASS_RST, gbfp_pkg::HIGHEST_CLASS_RST,
        gbfp_pkg::LONGEST_PAYLOAD_RST},
      '{16'd1,     8'h00, 8'hFF, 16'd0},
      '{16'd300,   8'h80, 8'hFF, 16'd16},
      '{16'd0,     8'h10, 8'h0F, 16'd8},
      '{16'hFFFF,  8'h01, 8'h28, 16'hFFFF},
      '{16'd2,     8'h00, 8'h00, 16'd3}
   };
   localparam int GAP_PCT [PHASES]   = '{0, 73, 0, 35, 0, 73};
   localparam int STALL_PCT [PHASES] = '{0, 0, 73, 35, 0, 0};

   logic   clock = 1'b0;
   logic   reset;
   int     gap_pct = 0;
   int     stall_pct = 0;
   int     phase_items = 0;
   bit     hold_wanted = 1'b0;
   bit     sprinkle_ticks = 1'b0;
   longint cycle_count = 0;

   frame_tracker tracker = new();

   gbfp_req_if req_chan ();
   gbfp_rsp_if rsp_chan ();
   gbfp_csr_if csr_chan ();

   gnss_binary_frame_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("gnss_binary_frame_parser verification failed");
         $finish;
      end
   end

   // result side: check accepted transactions, stall at random, one long hold-off
   initial begin : receiver
      int hold_left;
      bit hold_done;
      report_type seen;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            seen.status = gbfp_pkg::status_type'(rsp_chan.status);
            seen.payload_byte = rsp_chan.payload_byte;
            seen.payload_index = rsp_chan.payload_index;
            seen.msg_class = rsp_chan.msg_class;
            seen.msg_id = rsp_chan.msg_id;
            seen.msg_length = rsp_chan.msg_length;
            tracker.check_report(seen);
         end
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one input transaction, with an optional idle gap in front
   task automatic send_item(input logic is_tick, input logic [7:0] b);
      if ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= is_tick;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.take_item(is_tick, b);
      phase_items++;
   endtask

   // frame byte that counts towards the checksum, stray ticks in front if asked
   task automatic send_summed(input logic [7:0] b, inout logic [7:0] ca, inout logic [7:0] cb);
      if (sprinkle_ticks && $urandom_range(3) == 0)
         repeat ($urandom_range(2, 1)) send_item(1'b1, 8'($urandom));
      send_item(1'b0, b);
      ca = ca + b;
      cb = cb + ca;
   endtask

   // random frame, mostly well formed, sometimes with a flaw
   task automatic send_frame();
      logic [7:0]  cls;
      logic [7:0]  ca;
      logic [7:0]  cb;
      logic [15:0] len;
      int          flaw;
      int          cut;
      ca = '0;
      cb = '0;
      flaw = $urandom_range(9);
      sprinkle_ticks = (flaw == 9);
      if ($urandom_range(9) == 0) send_item(1'b0, gbfp_pkg::SYNC_FIRST);
      send_item(1'b0, gbfp_pkg::SYNC_FIRST);
      send_item(1'b0, gbfp_pkg::SYNC_SECOND);
      if (tracker.cfg.lowest_class <= tracker.cfg.highest_class && $urandom_range(9) != 0)
         cls = 8'($urandom_range(tracker.cfg.highest_class, tracker.cfg.lowest_class));
      else
         cls = 8'($urandom);
      send_summed(cls, ca, cb);
      if (cls < tracker.cfg.lowest_class || cls > tracker.cfg.highest_class) return;
      send_summed(8'($urandom), ca, cb);
      case ($urandom_range(7))
         0:       len = '0;
         1:       len = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
         default: len = 16'($urandom_range(12));
      endcase
      // keep accepted payloads short
      if (len <= tracker.cfg.longest_payload && len > 16'd40) len = {12'h000, len[3:0]};
      send_summed(len[7:0], ca, cb);
      send_summed(len[15:8], ca, cb);
      if (len > tracker.cfg.longest_payload) return;
      cut = $urandom_range(len);
      for (int k = 0; k < len; k++) begin
         if (flaw == 8 && k == cut) break;
         send_summed(8'($urandom), ca, cb);
      end
      // abandoned frame: let the silence run past the limit where that is cheap
      if (flaw == 8) begin
         if (tracker.cfg.gap_limit <= 16'd64)
            repeat (int'(tracker.cfg.gap_limit) + 1) send_item(1'b1, 8'($urandom));
         return;
      end
      send_item(1'b0, (flaw == 6) ? ca ^ 8'(1 << $urandom_range(7)) : ca);
      send_item(1'b0, (flaw == 7) ? cb ^ 8'(1 << $urandom_range(7)) : cb);
   endtask

   // stop offering and wait for every expected report
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write all four registers back to back
   task automatic load_config(input gbfp_pkg::cfg_type c);
      gbfp_pkg::csr_index_type regs [4] = '{gbfp_pkg::REG_GAP_LIMIT,
                                            gbfp_pkg::REG_LOWEST_CLASS,
                                            gbfp_pkg::REG_HIGHEST_CLASS,
                                            gbfp_pkg::REG_LONGEST_PAYLOAD};
      logic [15:0]   vals [4];
      vals = '{c.gap_limit, {8'h00, c.lowest_class}, {8'h00, c.highest_class},
               c.longest_payload};
      for (int i = 0; i < 4; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= regs[i];
         csr_chan.data <= vals[i];
         @(posedge clock);
         while (!csr_chan.ready) @(posedge clock);
         tracker.set_register(regs[i], vals[i]);
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] ca;
      logic [7:0] cb;
      int         pick;
      req_chan.valid <= 1'b0;
      req_chan.mode <= 1'b0;
      req_chan.data_byte <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= gbfp_pkg::REG_GAP_LIMIT;
      csr_chan.data <= '0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            load_config(PHASE_CFG[p]);
         end
         gap_pct = GAP_PCT[p];
         stall_pct = STALL_PCT[p];
         sprinkle_ticks = 1'b0;

         if (p == 0) begin
            // stray bytes, a tick while hunting, a broken sync pair
            send_item(1'b0, 8'h00);
            send_item(1'b0, 8'hFF);
            send_item(1'b1, 8'hA5);
            send_item(1'b0, gbfp_pkg::SYNC_FIRST);
            send_item(1'b0, 8'h00);
            // repeated first sync, lowest class, empty payload, good checksum
            ca = '0;
            cb = '0;
            send_item(1'b0, gbfp_pkg::SYNC_FIRST);
            send_item(1'b0, gbfp_pkg::SYNC_FIRST);
            send_item(1'b0, gbfp_pkg::SYNC_SECOND);
            send_summed(gbfp_pkg::LOWEST_CLASS_RST, ca, cb);
            send_summed(8'h00, ca, cb);
            send_summed(8'h00, ca, cb);
            send_summed(8'h00, ca, cb);
            send_item(1'b0, ca);
            send_item(1'b0, cb);
            // class just above the range
            send_item(1'b0, gbfp_pkg::SYNC_FIRST);
            send_item(1'b0, gbfp_pkg::SYNC_SECOND);
            send_item(1'b0, gbfp_pkg::HIGHEST_CLASS_RST + 8'h01);
            // highest class, one payload byte, first checksum byte wrong
            ca = '0;
            cb = '0;
            send_item(1'b0, gbfp_pkg::SYNC_FIRST);
            send_item(1'b0, gbfp_pkg::SYNC_SECOND);
            send_summed(gbfp_pkg::HIGHEST_CLASS_RST, ca, cb);
            send_summed(8'hFF, ca, cb);
            send_summed(8'h01, ca, cb);
            send_summed(8'h00, ca, cb);
            send_summed(8'h5A, ca, cb);
            send_item(1'b0, ca ^ 8'h01);
            send_item(1'b0, cb);
         end

         if (p == 4) begin
            // long silence mid-frame that stays under the limit
            ca = '0;
            cb = '0;
            send_item(1'b0, gbfp_pkg::SYNC_FIRST);
            send_item(1'b0, gbfp_pkg::SYNC_SECOND);
            send_summed(8'h05, ca, cb);
            send_summed(8'h01, ca, cb);
            send_summed(8'h02, ca, cb);
            send_summed(8'h00, ca, cb);
            send_summed(8'($urandom), ca, cb);
            repeat (40) send_item(1'b1, 8'($urandom));
            send_summed(8'($urandom), ca, cb);
            send_item(1'b0, ca);
            send_item(1'b0, cb);
         end

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if (p == 4 && phase_items >= 20) hold_wanted = 1'b1;
            pick = $urandom_range(9);
            if (pick < 8) begin
               send_frame();
            end else if (pick == 8) begin
               sprinkle_ticks = 1'b0;
               repeat ($urandom_range(6, 1))
                  send_item(1'b0, ($urandom_range(4) == 0) ? gbfp_pkg::SYNC_FIRST
                                                           : 8'($urandom));
            end else begin
               repeat ($urandom_range(4, 1)) send_item(1'b1, 8'($urandom));
            end
         end
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (tracker.failures == 0)
         $display("gnss_binary_frame_parser verification clean");
      else
         $display("gnss_binary_frame_parser verification failed");
      $finish;
   end

endmodule
